// ----- rtl/ssdd_pkg.sv -----
package ssdd_pkg;

    localparam int PIX_W       = 8;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int DIFF_W      = 18;
    localparam int DIFF_MAX    = 195075;

    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 13;
    localparam int THRESH_W     = 18;
    localparam int RATIO_W      = 14;
    localparam int CFG_DATA_W   = 18;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [THRESH_W-1:0]     THRESH_RESET = 18'd1000;
    localparam logic [RATIO_W-1:0]      RATIO_RESET  = 14'd100;

    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    localparam int BP_W = 14;
    localparam logic [BP_W-1:0] BP_SCALE = 14'd10000;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_RATIO        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] ref_red;
        logic [PIX_W-1:0] ref_green;
        logic [PIX_W-1:0] ref_blue;
        logic [PIX_W-1:0] test_red;
        logic [PIX_W-1:0] test_green;
        logic [PIX_W-1:0] test_blue;
    } pixel_t;

    typedef struct packed {
        logic               fabric_defective;
        logic [COUNT_W-1:0] defect_block_count;
        logic [COUNT_W-1:0] total_block_count;
    } result_t;

    // position class of one pixel pair, worked out on transfer
    typedef struct packed {
        pixel_t pix;
        logic   in_tile;
        logic   col_first;
        logic   col_last;
        logic   row_first;
        logic   row_last;
        logic   row_end;
        logic   frame_end;
    } item_t;

    function automatic logic [PIX_W-1:0] abs_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        if (a >= b)
        begin
            r = a - b;
        end
        else
        begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

// ----- rtl/ssdd_pixel_if.sv -----
interface ssdd_pixel_if;
    logic            valid;
    logic            ready;
    ssdd_pkg::pixel_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ssdd_result_if.sv -----
interface ssdd_result_if;
    logic             valid;
    logic             ready;
    ssdd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ssdd_ram.sv -----
module ssdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ssdd_fifo.sv -----
module ssdd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/ssdd_front.sv -----
module ssdd_front #(
    parameter int BLOCK      = 5,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW        = $clog2(MAX_WIDTH + 1),
    localparam int HW        = $clog2(MAX_HEIGHT + 1),
    localparam int TILE_COLS = MAX_WIDTH / BLOCK,
    localparam int ADDR_W    = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WW-1:0]     w,
    input  logic [HW-1:0]     h,
    ssdd_pixel_if.sink        pixel,
    output logic              push_valid,
    input  logic              push_ready,
    output ssdd_pkg::item_t   push_item,
    output logic [ADDR_W-1:0] push_addr
);

    localparam int PC_W   = $clog2(MAX_WIDTH);
    localparam int PR_W   = $clog2(MAX_HEIGHT);
    localparam int CB_W   = $clog2(BLOCK);
    localparam int BC_RAW = $clog2((MAX_WIDTH - 1) / BLOCK + 1);
    localparam int BC_W   = (BC_RAW > 1) ? BC_RAW : 1;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PR_W-1:0] pr_reg, pr_next;
    logic [CB_W-1:0] cib_reg, cib_next;
    logic [CB_W-1:0] rib_reg, rib_next;
    logic [BC_W-1:0] bc_reg, bc_next;

    logic accept;
    logic col_first, col_last, row_first, row_last;
    logic col_ok, row_ok, row_end, frame_end;

    assign accept     = pixel.valid && push_ready;
    assign pixel.ready = push_ready;
    assign push_valid = pixel.valid;

    assign col_first = cib_reg == '0;
    assign col_last  = cib_reg == CB_W'(BLOCK - 1);
    assign row_first = rib_reg == '0;
    assign row_last  = rib_reg == CB_W'(BLOCK - 1);

    // a pixel counts when the tile it sits in ends inside the image
    assign col_ok = ((WW+1)'(pc_reg) - (WW+1)'(cib_reg) + (WW+1)'(BLOCK)) <= (WW+1)'(w);
    assign row_ok = ((HW+1)'(pr_reg) - (HW+1)'(rib_reg) + (HW+1)'(BLOCK)) <= (HW+1)'(h);

    assign row_end   = ((WW+1)'(pc_reg) + (WW+1)'(1)) >= (WW+1)'(w);
    assign frame_end = row_end && (((HW+1)'(pr_reg) + (HW+1)'(1)) >= (HW+1)'(h));

    always_comb
    begin
        push_item.pix       = pixel.data;
        push_item.in_tile   = col_ok && row_ok;
        push_item.col_first = col_first;
        push_item.col_last  = col_last;
        push_item.row_first = row_first;
        push_item.row_last  = row_last;
        push_item.row_end   = row_end;
        push_item.frame_end = frame_end;
        push_addr           = bc_reg[ADDR_W-1:0];
    end

    always_comb
    begin
        pc_next  = pc_reg;
        pr_next  = pr_reg;
        cib_next = cib_reg;
        rib_next = rib_reg;
        bc_next  = bc_reg;
        if (accept)
        begin
            if (col_last)
            begin
                cib_next = '0;
                bc_next  = bc_reg + BC_W'(1);
            end
            else
            begin
                cib_next = cib_reg + CB_W'(1);
            end
            if (row_end)
            begin
                pc_next  = '0;
                cib_next = '0;
                bc_next  = '0;
                rib_next = row_last ? '0 : rib_reg + CB_W'(1);
                if (frame_end)
                begin
                    pr_next  = '0;
                    rib_next = '0;
                end
                else
                begin
                    pr_next = pr_reg + PR_W'(1);
                end
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            pr_reg  <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            bc_reg  <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            pr_reg  <= pr_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            bc_reg  <= bc_next;
        end
    end

endmodule

// ----- rtl/ssdd_back.sv -----
module ssdd_back #(
    parameter int BLOCK      = 5,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW        = $clog2(MAX_WIDTH + 1),
    localparam int HW        = $clog2(MAX_HEIGHT + 1),
    localparam int TILE_COLS = MAX_WIDTH / BLOCK,
    localparam int ADDR_W    = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [WW-1:0]                 w,
    input  logic [HW-1:0]                 h,
    input  logic [ssdd_pkg::THRESH_W-1:0] threshold,
    input  logic [ssdd_pkg::RATIO_W-1:0]  ratio,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  ssdd_pkg::item_t               pop_item,
    input  logic [ADDR_W-1:0]             pop_addr,
    ssdd_result_if.source                 result
);

    localparam int CW     = ssdd_pkg::COUNT_W;
    localparam int LOG_B  = $clog2(BLOCK);
    localparam int SHX    = WW + LOG_B;
    localparam int SHY    = HW + LOG_B;
    localparam int RECX   = ((2 ** SHX) + BLOCK - 1) / BLOCK;
    localparam int RECY   = ((2 ** SHY) + BLOCK - 1) / BLOCK;
    localparam int PX_W   = 2 * WW + 1;
    localparam int PY_W   = 2 * HW + 1;
    localparam int TX_W   = $clog2(MAX_WIDTH / BLOCK + 1);
    localparam int TY_W   = $clog2(MAX_HEIGHT / BLOCK + 1);
    localparam int TW     = TX_W + TY_W;
    localparam int RS_W   = $clog2(BLOCK * ssdd_pkg::DIFF_MAX + 1);
    localparam int CS_W   = $clog2(BLOCK * BLOCK * ssdd_pkg::DIFF_MAX + 1);
    localparam int THR_W  = ssdd_pkg::THRESH_W + $clog2(BLOCK * BLOCK + 1);
    localparam int CMP1_W = (CS_W > THR_W) ? CS_W : THR_W;
    localparam int PA_W   = CW + ssdd_pkg::BP_W;
    localparam int PB_W   = ssdd_pkg::RATIO_W + TW;
    localparam int VW     = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int SAT_W  = (TW > CW) ? TW : CW;

    // frame constants are registered and follow the configuration inputs
    logic [TX_W-1:0]  tiles_x_reg;
    logic [TY_W-1:0]  tiles_y_reg;
    logic [THR_W-1:0] thr_reg;
    logic [TW-1:0]    tiles_reg;
    logic [PB_W-1:0]  ratio_tiles_reg;
    logic [PX_W-1:0]  wprod;
    logic [PY_W-1:0]  hprod;

    assign wprod = PX_W'(w) * PX_W'(RECX);
    assign hprod = PY_W'(h) * PY_W'(RECY);

    always_ff @(posedge clk)
    begin
        tiles_x_reg     <= TX_W'(wprod >> SHX);
        tiles_y_reg     <= TY_W'(hprod >> SHY);
        thr_reg         <= THR_W'(threshold) * THR_W'(BLOCK * BLOCK);
        tiles_reg       <= TW'(tiles_x_reg) * TW'(tiles_y_reg);
        ratio_tiles_reg <= PB_W'(ratio) * PB_W'(tiles_reg);
    end

    logic en;
    logic out_valid_reg;
    ssdd_pkg::result_t out_data_reg;

    // the back pipeline holds only while a finished result is not taken
    assign en        = !(out_valid_reg && !result.ready);
    assign pop_ready = en;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    ssdd_pkg::item_t               item1_reg, item2_reg, item3_reg, item4_reg, item5_reg;
    logic [ADDR_W-1:0]             addr1_reg, addr2_reg, addr3_reg, addr4_reg;
    logic [ssdd_pkg::SQ_W-1:0]     sq_red2_reg, sq_green2_reg, sq_blue2_reg;
    logic [ssdd_pkg::DIFF_W-1:0]   d3_reg;
    logic [RS_W-1:0]               rs4_reg;
    logic [CS_W-1:0]               cs5_reg;
    logic [CW-1:0]                 snap6_reg, snap7_reg;
    logic [PA_W-1:0]               pa7_reg;
    logic [PB_W-1:0]               pb7_reg;
    logic                          nz7_reg;
    logic [CW-1:0]                 sat7_reg;
    logic [RS_W-1:0]               row_sum_reg;
    logic [CW-1:0]                 count_reg;

    logic [ssdd_pkg::PIX_W-1:0]    ad_red, ad_green, ad_blue;
    logic [RS_W-1:0]               rs;
    logic [CS_W-1:0]               cs;
    logic [CS_W-1:0]               col_rd;
    logic                          rd_en, wr_en;
    logic                          hit;
    logic [CW-1:0]                 count_inc;
    logic [CW-1:0]                 tiles_sat;
    logic                          verdict;

    assign ad_red   = ssdd_pkg::abs_diff(item1_reg.pix.ref_red, item1_reg.pix.test_red);
    assign ad_green = ssdd_pkg::abs_diff(item1_reg.pix.ref_green, item1_reg.pix.test_green);
    assign ad_blue  = ssdd_pkg::abs_diff(item1_reg.pix.ref_blue, item1_reg.pix.test_blue);

    assign rs = (item3_reg.col_first ? '0 : row_sum_reg) + RS_W'(d3_reg);
    assign rd_en = en && v3_reg && item3_reg.in_tile && item3_reg.col_last
                   && !item3_reg.row_first;

    assign cs    = (item4_reg.row_first ? '0 : col_rd) + CS_W'(rs4_reg);
    assign wr_en = en && v4_reg && item4_reg.in_tile && item4_reg.col_last;

    assign hit = item5_reg.in_tile && item5_reg.col_last && item5_reg.row_last
                 && (CMP1_W'(cs5_reg) > CMP1_W'(thr_reg));
    assign count_inc = (hit && count_reg != ssdd_pkg::COUNT_MAX)
                       ? count_reg + CW'(1) : count_reg;

    assign tiles_sat = (SAT_W'(tiles_reg) > SAT_W'(ssdd_pkg::COUNT_MAX))
                       ? ssdd_pkg::COUNT_MAX : CW'(tiles_reg);
    assign verdict   = nz7_reg && (VW'(pa7_reg) > VW'(pb7_reg));

    ssdd_ram #(
        .WIDTH (CS_W),
        .DEPTH (TILE_COLS)
    ) u_col_sums (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr4_reg),
        .wr_data (cs),
        .rd_en   (rd_en),
        .rd_addr (addr3_reg),
        .rd_data (col_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            row_sum_reg   <= '0;
            count_reg     <= '0;
        end
        else if (en)
        begin
            v1_reg        <= pop_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg && item5_reg.frame_end;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
            if (v3_reg)
            begin
                if (item3_reg.row_end)
                begin
                    row_sum_reg <= '0;
                end
                else if (item3_reg.in_tile)
                begin
                    row_sum_reg <= rs;
                end
            end
            if (v5_reg)
            begin
                count_reg <= item5_reg.frame_end ? '0 : count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg     <= pop_item;
            addr1_reg     <= pop_addr;
            item2_reg     <= item1_reg;
            addr2_reg     <= addr1_reg;
            sq_red2_reg   <= ssdd_pkg::SQ_W'(ad_red) * ssdd_pkg::SQ_W'(ad_red);
            sq_green2_reg <= ssdd_pkg::SQ_W'(ad_green) * ssdd_pkg::SQ_W'(ad_green);
            sq_blue2_reg  <= ssdd_pkg::SQ_W'(ad_blue) * ssdd_pkg::SQ_W'(ad_blue);
            item3_reg     <= item2_reg;
            addr3_reg     <= addr2_reg;
            d3_reg        <= ssdd_pkg::DIFF_W'(sq_red2_reg)
                             + ssdd_pkg::DIFF_W'(sq_green2_reg)
                             + ssdd_pkg::DIFF_W'(sq_blue2_reg);
            item4_reg     <= item3_reg;
            addr4_reg     <= addr3_reg;
            rs4_reg       <= rs;
            item5_reg     <= item4_reg;
            cs5_reg       <= cs;
            snap6_reg     <= count_inc;
            snap7_reg     <= snap6_reg;
            pa7_reg       <= PA_W'(snap6_reg) * PA_W'(ssdd_pkg::BP_SCALE);
            pb7_reg       <= ratio_tiles_reg;
            nz7_reg       <= tiles_reg != '0;
            sat7_reg      <= tiles_sat;
            if (v7_reg)
            begin
                out_data_reg.fabric_defective   <= verdict;
                out_data_reg.defect_block_count <= snap7_reg;
                out_data_reg.total_block_count  <= sat7_reg;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// ----- rtl/block_ssd_defect_detector.sv -----
// Tile squared-difference defect detector.
// pixel: one reference/test RGB pair per transfer, raster order, valid/ready.
// result: one transfer per frame, sent after the last pixel of the frame:
// verdict, defective tile count and full tile count (both saturate).
// Configuration: cfg_write with cfg_index/cfg_data writes image width,
// image height, mean threshold or defect ratio; take effect from the next
// pixel, write them only with no frame result outstanding.
// Throughput: one pixel per clock while pixel.ready is high. The result is
// valid after the last pixel of a frame has passed the queue, the 7-stage back
// pipeline (squares, sum, row add, column store read, column add, compare,
// verdict products) and the output register.
// A 4-entry queue sits between pixel classification and the back pipeline;
// while a result waits on result.ready the back pipeline holds and the
// queue keeps taking pixels until it fills, then pixel.ready drops.
// Reset: registers return to 640 x 480, threshold 1000, ratio 100 basis
// points, frame position and counts clear. The column sum store is not
// cleared; every entry is written on the first tile row before being read.
module block_ssd_defect_detector #(
    parameter int BLOCK      = 5,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  ssdd_pkg::cfg_index_t            cfg_index,
    input  logic [ssdd_pkg::CFG_DATA_W-1:0] cfg_data,
    ssdd_pixel_if.sink                      pixel,
    ssdd_result_if.source                   result
);

    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int TILE_COLS = MAX_WIDTH / BLOCK;
    localparam int ADDR_W    = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int ITEM_W    = $bits(ssdd_pkg::item_t);
    localparam int Q_W       = ITEM_W + ADDR_W;
    localparam int Q_DEPTH   = 4;

    logic [ssdd_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [ssdd_pkg::HEIGHT_REG_W-1:0] image_height_reg;
    logic [ssdd_pkg::THRESH_W-1:0]     threshold_reg;
    logic [ssdd_pkg::RATIO_W-1:0]      ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= ssdd_pkg::WIDTH_RESET;
            image_height_reg <= ssdd_pkg::HEIGHT_RESET;
            threshold_reg    <= ssdd_pkg::THRESH_RESET;
            ratio_reg        <= ssdd_pkg::RATIO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ssdd_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg  <= cfg_data[ssdd_pkg::WIDTH_REG_W-1:0];
                ssdd_pkg::CFG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[ssdd_pkg::HEIGHT_REG_W-1:0];
                ssdd_pkg::CFG_THRESHOLD:
                    threshold_reg    <= cfg_data[ssdd_pkg::THRESH_W-1:0];
                ssdd_pkg::CFG_RATIO:
                    ratio_reg        <= cfg_data[ssdd_pkg::RATIO_W-1:0];
                default:
                    ratio_reg        <= ratio_reg;
            endcase
        end
    end

    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;

    // sizes clamped to 1..max
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_clamp = WW'(1);
        end
        else if ({1'b0, image_width_reg} > 14'(MAX_WIDTH))
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WW'(image_width_reg);
        end
        if (image_height_reg == '0)
        begin
            h_clamp = HW'(1);
        end
        else if ({1'b0, image_height_reg} > 14'(MAX_HEIGHT))
        begin
            h_clamp = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = HW'(image_height_reg);
        end
    end

    logic              push_valid;
    logic              push_ready;
    ssdd_pkg::item_t   push_item;
    logic [ADDR_W-1:0] push_addr;
    logic              pop_valid;
    logic              pop_ready;
    ssdd_pkg::item_t   pop_item;
    logic [ADDR_W-1:0] pop_addr;
    logic [Q_W-1:0]    q_in;
    logic [Q_W-1:0]    q_out;

    assign q_in                 = {push_item, push_addr};
    assign {pop_item, pop_addr} = q_out;

    ssdd_front #(
        .BLOCK      (BLOCK),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .w          (w_clamp),
        .h          (h_clamp),
        .pixel      (pixel),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_addr  (push_addr)
    );

    ssdd_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (q_in),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (q_out)
    );

    ssdd_back #(
        .BLOCK      (BLOCK),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .w         (w_clamp),
        .h         (h_clamp),
        .threshold (threshold_reg),
        .ratio     (ratio_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .pop_addr  (pop_addr),
        .result    (result)
    );

endmodule

// ----- tb/block_ssd_defect_detector_tb.sv -----
module block_ssd_defect_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef ssdd_pkg::pixel_t     pixel_t;
    typedef ssdd_pkg::result_t    result_t;
    typedef ssdd_pkg::cfg_index_t cfg_index_t;

    localparam int PIX_W        = ssdd_pkg::PIX_W;
    localparam int COUNT_W      = ssdd_pkg::COUNT_W;
    localparam int CFG_DATA_W   = ssdd_pkg::CFG_DATA_W;
    localparam int WIDTH_REG_W  = ssdd_pkg::WIDTH_REG_W;
    localparam int HEIGHT_REG_W = ssdd_pkg::HEIGHT_REG_W;
    localparam int THRESH_W     = ssdd_pkg::THRESH_W;
    localparam int RATIO_W      = ssdd_pkg::RATIO_W;
    localparam int DIFF_MAX     = ssdd_pkg::DIFF_MAX;

    localparam logic [COUNT_W-1:0]    COUNT_MAX = ssdd_pkg::COUNT_MAX;
    localparam logic [ssdd_pkg::BP_W-1:0] BP_SCALE = ssdd_pkg::BP_SCALE;

    localparam int TILE         = 5;
    localparam int MAX_SIDE     = 4096;
    localparam int TILE_COLS    = MAX_SIDE / TILE;
    localparam int LONG_HOLD    = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int THRESH_TOP   = (1 << THRESH_W) - 1;
    localparam int RATIO_TOP    = (1 << RATIO_W) - 1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    cfg_index_t            cfg_index = ssdd_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic   px_valid = 1'b0;
    pixel_t px_data  = '0;
    logic   rx_ready = 1'b0;

    ssdd_pixel_if  pixel_ch ();
    ssdd_result_if result_ch ();

    assign pixel_ch.valid = px_valid;
    assign pixel_ch.data  = px_data;
    assign result_ch.ready = rx_ready;

    block_ssd_defect_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    // stimulus and expectations
    pixel_t  pixel_q [$];
    result_t frame_verdicts_q [$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      frames_sent    = 0;

    // idling controls; the throttles and hold requests are written on the falling edge
    logic tx_throttle  = 1'b0;
    logic rx_throttle  = 1'b0;
    int   holds_asked  = 0;
    int   holds_served = 0;
    int   tx_gap       = 0;
    int   rx_stall     = 0;
    int   quiet_cycles = 0;

    // register copies and frame state of the detector
    bit [WIDTH_REG_W-1:0]  reg_width  = ssdd_pkg::WIDTH_RESET;
    bit [HEIGHT_REG_W-1:0] reg_height = ssdd_pkg::HEIGHT_RESET;
    bit [THRESH_W-1:0]     reg_thresh = ssdd_pkg::THRESH_RESET;
    bit [RATIO_W-1:0]      reg_ratio  = ssdd_pkg::RATIO_RESET;

    bit [31:0]   tile_col_sum [TILE_COLS];
    bit [31:0]   tile_row_sum = 0;
    int unsigned pix_col      = 0;
    int unsigned pix_row      = 0;
    int unsigned col_in_tile  = 0;
    int unsigned row_in_tile  = 0;
    int unsigned tile_col     = 0;
    int unsigned defect_tiles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int unsigned clamp_side(int unsigned v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > MAX_SIDE) ? MAX_SIDE : v;
    endfunction

    function automatic int unsigned chan_sq(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    // one pixel pair through the tile accumulator; frame end pushes the verdict
    function automatic void score_pixel_pair(pixel_t p);
        int unsigned     w;
        int unsigned     h;
        int unsigned     tiles_x;
        int unsigned     tiles_y;
        int unsigned     pair_ssd;
        bit [31:0]       tile_sum;
        longint unsigned tiles;
        result_t         verdict;
        w = clamp_side(32'(reg_width));
        h = clamp_side(32'(reg_height));
        tiles_x = w / TILE;
        tiles_y = h / TILE;
        pair_ssd = chan_sq(p.ref_red, p.test_red) + chan_sq(p.ref_green, p.test_green)
                 + chan_sq(p.ref_blue, p.test_blue);
        if (pix_col < tiles_x * TILE && pix_row < tiles_y * TILE)
        begin
            tile_row_sum = ((col_in_tile == 0) ? 0 : tile_row_sum) + pair_ssd;
            if (col_in_tile == TILE - 1)
            begin
                tile_sum = ((row_in_tile == 0) ? 0 : tile_col_sum[tile_col]) + tile_row_sum;
                tile_col_sum[tile_col] = tile_sum;
                if (row_in_tile == TILE - 1 && tile_sum > 32'(reg_thresh) * TILE * TILE
                    && defect_tiles < 32'(COUNT_MAX))
                begin
                    defect_tiles++;
                end
            end
        end
        col_in_tile++;
        if (col_in_tile >= TILE)
        begin
            col_in_tile = 0;
            tile_col++;
        end
        if (pix_col + 1 >= w)
        begin
            pix_col = 0;
            col_in_tile = 0;
            tile_col = 0;
            tile_row_sum = 0;
            row_in_tile = (row_in_tile + 1 >= TILE) ? 0 : row_in_tile + 1;
            if (pix_row + 1 >= h)
            begin
                tiles = longint'(tiles_x) * tiles_y;
                verdict.fabric_defective = (tiles != 0)
                    && (longint'(defect_tiles) * 64'(BP_SCALE) > longint'(reg_ratio) * tiles);
                verdict.defect_block_count = defect_tiles[COUNT_W-1:0];
                verdict.total_block_count = (tiles > 64'(COUNT_MAX)) ? COUNT_MAX
                                                                     : tiles[COUNT_W-1:0];
                frame_verdicts_q.push_back(verdict);
                pix_row = 0;
                row_in_tile = 0;
                defect_tiles = 0;
            end
            else
            begin
                pix_row++;
            end
        end
        else
        begin
            pix_col++;
        end
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_valid <= 1'b0;
            px_data <= '0;
            tx_gap <= 0;
        end
        else if (!px_valid || pixel_ch.ready)
        begin
            if (px_valid)
            begin
                score_pixel_pair(px_data);
            end
            if (tx_gap != 0)
            begin
                px_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pixel_q.size() == 0)
            begin
                px_valid <= 1'b0;
            end
            else if (tx_throttle && $urandom_range(0, 5) == 0)
            begin
                px_valid <= 1'b0;
                tx_gap <= $urandom_range(0, 3);
            end
            else
            begin
                px_valid <= 1'b1;
                px_data <= pixel_q.pop_front();
            end
        end
    end

    // result monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        result_t want;
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            if (result_ch.valid && rx_ready)
            begin
                if (frame_verdicts_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %0d %0d %0d", $time,
                             result_ch.data.fabric_defective,
                             result_ch.data.defect_block_count,
                             result_ch.data.total_block_count);
                    mismatch_count++;
                end
                else
                begin
                    want = frame_verdicts_q.pop_front();
                    if (result_ch.data.fabric_defective !== want.fabric_defective)
                    begin
                        $display("%0t: fabric_defective expected %0d, got %0d", $time,
                                 want.fabric_defective, result_ch.data.fabric_defective);
                        mismatch_count++;
                    end
                    if (result_ch.data.defect_block_count !== want.defect_block_count)
                    begin
                        $display("%0t: defect_block_count expected %0d, got %0d", $time,
                                 want.defect_block_count, result_ch.data.defect_block_count);
                        mismatch_count++;
                    end
                    if (result_ch.data.total_block_count !== want.total_block_count)
                    begin
                        $display("%0t: total_block_count expected %0d, got %0d", $time,
                                 want.total_block_count, result_ch.data.total_block_count);
                        mismatch_count++;
                    end
                end
            end
            if (rx_stall != 0)
            begin
                rx_ready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else if (holds_served != holds_asked)
            begin
                rx_ready <= 1'b0;
                rx_stall <= LONG_HOLD - 1;
                holds_served <= holds_asked;
            end
            else if (rx_throttle && $urandom_range(0, 6) == 0)
            begin
                rx_ready <= 1'b0;
                rx_stall <= $urandom_range(0, 3);
            end
            else
            begin
                rx_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((px_valid && pixel_ch.ready) || (result_ch.valid && rx_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("block_ssd_defect_detector_tb: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic program_regs(int unsigned w, int unsigned h, int unsigned th,
                                int unsigned ratio);
        put_reg(ssdd_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        put_reg(ssdd_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        put_reg(ssdd_pkg::CFG_THRESHOLD, CFG_DATA_W'(th));
        put_reg(ssdd_pkg::CFG_RATIO, CFG_DATA_W'(ratio));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        reg_width = WIDTH_REG_W'(w);
        reg_height = HEIGHT_REG_W'(h);
        reg_thresh = THRESH_W'(th);
        reg_ratio = RATIO_W'(ratio);
    endtask

    // wait until every pixel is taken and every verdict has come back
    task automatic settle(int extra);
        do
        begin
            @(negedge clk);
        end
        while (pixel_q.size() != 0 || px_valid || frame_verdicts_q.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] nudge(logic [PIX_W-1:0] v, int amp);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * amp)) - amp;
        if (t < 0)
        begin
            t = 0;
        end
        if (t > 255)
        begin
            t = 255;
        end
        return t[PIX_W-1:0];
    endfunction

    function automatic pixel_t make_pair(int amp, int damage);
        pixel_t p;
        p.ref_red = PIX_W'($urandom_range(0, 255));
        p.ref_green = PIX_W'($urandom_range(0, 255));
        p.ref_blue = PIX_W'($urandom_range(0, 255));
        p.test_red = p.ref_red;
        p.test_green = p.ref_green;
        p.test_blue = p.ref_blue;
        if ($urandom_range(1, 100) <= damage)
        begin
            p.test_red = nudge(p.ref_red, amp);
            p.test_green = nudge(p.ref_green, amp);
            p.test_blue = nudge(p.ref_blue, amp);
        end
        return p;
    endfunction

    task automatic queue_frame(int amp, int damage);
        int unsigned npix;
        npix = clamp_side(32'(reg_width)) * clamp_side(32'(reg_height));
        for (int unsigned i = 0; i < npix; i++)
        begin
            pixel_q.push_back(make_pair(amp, damage));
        end
        items_sent += npix;
        frames_sent++;
    endtask

    initial
    begin
        int          amp;
        int          damage;
        int          mean;
        int unsigned w;
        int unsigned h;
        int unsigned th;
        int unsigned ratio;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // one 5x5 tile with zero threshold: any difference makes it defective
        program_regs(5, 5, 0, 0);
        pixel_q.push_back(pixel_t'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
        pixel_q.push_back(pixel_t'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
        pixel_q.push_back(pixel_t'{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
        pixel_q.push_back(pixel_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        pixel_q.push_back(pixel_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        for (int i = 0; i < 20; i++)
        begin
            pixel_q.push_back(make_pair(0, 0));
        end
        settle(DRAIN_CYCLES);

        // zero size clamps to a single pixel, no tiles, top threshold and ratio
        program_regs(0, 0, THRESH_TOP, RATIO_TOP);
        pixel_q.push_back(pixel_t'{8'h12, 8'hED, 8'h80, 8'h7F, 8'h01, 8'hFE});
        settle(DRAIN_CYCLES);

        // single-pixel frames under a long receiver hold so the input backs up
        program_regs(1, 1, 10, 5000);
        holds_asked = holds_asked + 1;
        for (int i = 0; i < 30; i++)
        begin
            pixel_q.push_back(make_pair(255, 50));
        end
        settle(DRAIN_CYCLES);
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            pixel_q.push_back(make_pair(255, 50));
        end
        settle(0);
        for (int i = 0; i < 10; i++)
        begin
            pixel_q.push_back(make_pair(255, 50));
        end
        settle(DRAIN_CYCLES);

        items_sent = 0;
        frames_sent = 0;
        while (frames_sent < 10 || items_sent < 440)
        begin
            case ($urandom_range(0, 4))
                0: amp = 0;
                1: amp = 3;
                2: amp = 20;
                3: amp = 80;
                default: amp = 255;
            endcase
            damage = $urandom_range(0, 100);
            mean = amp * amp * damage / 100;
            th = $urandom_range(0, 2 * mean + 1);
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: th = 0;
                    1: th = DIFF_MAX;
                    default: th = THRESH_TOP;
                endcase
            end
            ratio = $urandom_range(0, 10000);
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: ratio = 0;
                    1: ratio = 10000;
                    default: ratio = RATIO_TOP;
                endcase
            end
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 10);
            case ($urandom_range(0, 9))
                0: w = 0;
                1: h = 0;
                2: w = $urandom_range(20, 40);
                default: ;
            endcase
            program_regs(w, h, th, ratio);
            tx_throttle = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);
            for (int f = $urandom_range(1, 3); f > 0; f--)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    settle(0);
                end
                queue_frame(amp, damage);
            end
            settle(DRAIN_CYCLES);
        end

        // closing stretch without idling
        tx_throttle = 1'b0;
        rx_throttle = 1'b0;
        program_regs(10, 10, 500, 2500);
        queue_frame(40, 60);
        queue_frame(40, 60);
        settle(DRAIN_CYCLES);

        if (mismatch_count == 0)
        begin
            $display("block_ssd_defect_detector_tb: clean");
        end
        else
        begin
            $display("block_ssd_defect_detector_tb: errors");
        end
        $finish;
    end

endmodule

// ----- block_ssd_defect_detector.f -----
rtl/ssdd_pkg.sv
rtl/ssdd_pixel_if.sv
rtl/ssdd_result_if.sv
rtl/ssdd_ram.sv
rtl/ssdd_fifo.sv
rtl/ssdd_front.sv
rtl/ssdd_back.sv
rtl/block_ssd_defect_detector.sv
tb/block_ssd_defect_detector_tb.sv
